// ----- rtl/core/climate_threshold_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Climate threshold controller assertion macros
// Shared concurrent check forms for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef CLIMATE_THRESHOLD_CONTROLLER_ASSERT_SVH
`define CLIMATE_THRESHOLD_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked on the rising clock outside reset
`define CTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ctc: same-cycle check failed");

// next-cycle implication, checked on the rising clock outside reset
`define CTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ctc: next-cycle check failed");

`endif

// ----- rtl/core/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctc_pkg
// Types, codes and constants of the climate threshold controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    // item kinds on the input tuser bit
    localparam logic FUNC_KEY    = 1'b0;
    localparam logic FUNC_SENSOR = 1'b1;

    // decoded key codes
    localparam logic [2:0] KEY_NONE   = 3'd0;
    localparam logic [2:0] KEY_UP     = 3'd1;
    localparam logic [2:0] KEY_DOWN   = 3'd2;
    localparam logic [2:0] KEY_LEFT   = 3'd3;
    localparam logic [2:0] KEY_RIGHT  = 3'd4;
    localparam logic [2:0] KEY_CENTER = 3'd5;

    // keypad windows, both bounds exclusive
    localparam logic [11:0] UP_LO     = 12'd2156;
    localparam logic [11:0] UP_HI     = 12'd2200;
    localparam logic [11:0] DOWN_LO   = 12'd570;
    localparam logic [11:0] DOWN_HI   = 12'd610;
    localparam logic [11:0] LEFT_LO   = 12'd1600;
    localparam logic [11:0] LEFT_HI   = 12'd1630;
    localparam logic [11:0] RIGHT_LO  = 12'd3030;
    localparam logic [11:0] RIGHT_HI  = 12'd3080;
    localparam logic [11:0] CENTER_LO = 12'd2600;
    localparam logic [11:0] CENTER_HI = 12'd2650;

    // threshold slots
    localparam logic [1:0] TH_TEMP_UP  = 2'd0;
    localparam logic [1:0] TH_TEMP_LOW = 2'd1;
    localparam logic [1:0] TH_HUM_UP   = 2'd2;
    localparam logic [1:0] TH_HUM_LOW  = 2'd3;

    typedef logic [3:0][7:0] t_thr;

    localparam t_thr THR_RESET = {8'd55, 8'd70, 8'd27, 8'd35};

    typedef struct packed {
        logic        func;
        logic [11:0] key_level;
        logic [7:0]  humidity;
        logic [7:0]  temp_whole;
        logic [3:0]  temp_tenths;
    } t_item;

    typedef struct packed {
        logic       heater_on;
        logic       cooler_on;
        logic       fan_on;
        logic       setting_mode;
        logic [1:0] selected_item;
        logic [2:0] key_code;
    } t_status;

    // x*10 as shift-and-add, widened to 12 bits
    function automatic logic [11:0] times10(input logic [7:0] x);
        logic [11:0] w;
        w = {4'd0, x};
        return (w << 3) + (w << 1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/climate_threshold_controller.sv -----
// ----------------------------------------------------------------------------
// climate_threshold_controller
// Keypad threshold menu plus heater, cooler and fan control on sensor items.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: func; tdata[31:0]: key_level, humidity,
//                       temp_whole, temp_tenths
//  m_axis    out        tdata[15:0]: heater_on, cooler_on, fan_on,
//                       setting_mode, selected_item, key_code, zero pad
//
//  One item per cycle sustained while results are taken; every accepted item yields one result.
//  Each item passes the input register, then one pass of decode, compare
//  and state update into the result register.
//  Synchronous active-low reset puts thresholds at 35, 27, 70, 55, run mode,
//  selection 0 and all drives off.
//  A stalled result holds the input register; the input stays ready while
//  that register is empty or moves on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "climate_threshold_controller_assert.svh"

module climate_threshold_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // key_level, humidity, temp_whole, temp_tenths
    input  wire logic        i_s_axis_tuser,   // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata    // heater_on, cooler_on, fan_on, setting_mode,
                                               // selected_item, key_code, pad
);
    import ctc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_status r_out;

    logic    w_step;
    t_status w_status;

    // advance the held item whenever the result slot is free or draining
    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // capture the transfer; unpack tdata from the low bits up
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.func        <= i_s_axis_tuser;
            r_in.key_level   <= i_s_axis_tdata[11:0];
            r_in.humidity    <= i_s_axis_tdata[19:12];
            r_in.temp_whole  <= i_s_axis_tdata[27:20];
            r_in.temp_tenths <= i_s_axis_tdata[31:28];
        end
    end

    ctc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the result register; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0,
                              r_out.key_code,
                              r_out.selected_item,
                              r_out.setting_mode,
                              r_out.fan_on,
                              r_out.cooler_on,
                              r_out.heater_on};

    `CTC_ASSERT_NEXT(a_step_fills_out, w_step, r_out_valid)
    `CTC_ASSERT_NOW(a_step_needs_room, w_step, r_in_valid && (!r_out_valid || i_m_axis_tready))
    `CTC_ASSERT_NEXT(a_stall_keeps_in,
        r_in_valid && r_out_valid && !i_m_axis_tready,
        r_in_valid && $stable(r_in))

endmodule

`default_nettype wire

// ----- rtl/core/ctc_key_decode.sv -----
// ----------------------------------------------------------------------------
// ctc_key_decode
// Window decoder for the resistor-ladder keypad level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_key_decode (
    input  wire logic [11:0] i_level,
    output logic      [2:0]  o_key
);
    import ctc_pkg::*;

    always_comb begin
        priority if (i_level > UP_LO && i_level < UP_HI) begin
            o_key = KEY_UP;
        end else if (i_level > DOWN_LO && i_level < DOWN_HI) begin
            o_key = KEY_DOWN;
        end else if (i_level > LEFT_LO && i_level < LEFT_HI) begin
            o_key = KEY_LEFT;
        end else if (i_level > RIGHT_LO && i_level < RIGHT_HI) begin
            o_key = KEY_RIGHT;
        end else if (i_level > CENTER_LO && i_level < CENTER_HI) begin
            o_key = KEY_CENTER;
        end else begin
            o_key = KEY_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ctc_core.sv -----
// ----------------------------------------------------------------------------
// ctc_core
// Menu state, thresholds and drive bits; updated once per stepped item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "climate_threshold_controller_assert.svh"

module ctc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire ctc_pkg::t_item   i_item,
    output ctc_pkg::t_status      o_status
);
    import ctc_pkg::*;

    logic        r_menu_active, n_menu_active;
    logic [1:0]  r_selection,   n_selection;
    t_thr        r_edit,        n_edit;
    t_thr        r_active,      n_active;
    logic        r_heater,      n_heater;
    logic        r_cooler,      n_cooler;
    logic        r_fan,         n_fan;

    logic [2:0]  w_key;
    logic [11:0] w_temp;
    logic [11:0] w_tup;
    logic [11:0] w_tlo;
    logic [7:0]  w_hup;
    logic [7:0]  w_hlo;

    ctc_key_decode u_key_decode (
        .i_level (i_item.key_level),
        .o_key   (w_key)
    );

    // temperature in tenths; tenths above nine pass through unclamped
    assign w_temp = times10(i_item.temp_whole) + {8'd0, i_item.temp_tenths};
    assign w_tup  = times10(r_active[TH_TEMP_UP]);
    assign w_tlo  = times10(r_active[TH_TEMP_LOW]);
    assign w_hup  = r_active[TH_HUM_UP];
    assign w_hlo  = r_active[TH_HUM_LOW];

    always_comb begin
        n_menu_active = r_menu_active;
        n_selection   = r_selection;
        n_edit        = r_edit;
        n_active      = r_active;
        n_heater      = r_heater;
        n_cooler      = r_cooler;
        n_fan         = r_fan;
        if (i_step) begin
            if (i_item.func == FUNC_KEY) begin
                unique case (w_key)
                    KEY_CENTER: begin
                        n_menu_active = ~r_menu_active;
                        // leaving the menu commits the edited set
                        if (r_menu_active) begin
                            n_active = r_edit;
                        end
                    end
                    KEY_LEFT: begin
                        if (r_menu_active) begin
                            n_selection = r_selection - 2'd1;
                        end
                    end
                    KEY_RIGHT: begin
                        if (r_menu_active) begin
                            n_selection = r_selection + 2'd1;
                        end
                    end
                    KEY_UP: begin
                        if (r_menu_active) begin
                            n_edit[r_selection] = r_edit[r_selection] + 8'd1;
                        end
                    end
                    KEY_DOWN: begin
                        if (r_menu_active) begin
                            n_edit[r_selection] = r_edit[r_selection] - 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (!r_menu_active) begin
                priority if (w_temp < w_tlo) begin
                    n_heater = 1'b1;
                end else if (w_temp > w_tlo) begin
                    n_heater = 1'b0;
                end else begin
                    n_heater = r_heater;
                end

                priority if (i_item.humidity > w_hup || w_temp > w_tup) begin
                    n_cooler = 1'b1;
                end else if (i_item.humidity <= w_hlo || w_temp <= w_tlo) begin
                    n_cooler = 1'b0;
                end else begin
                    n_cooler = r_cooler;
                end

                priority if (i_item.humidity > w_hup) begin
                    n_fan = 1'b1;
                end else if (i_item.humidity <= w_hlo) begin
                    n_fan = 1'b0;
                end else begin
                    n_fan = r_fan;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu_active <= 1'b0;
            r_selection   <= 2'd0;
            r_edit        <= THR_RESET;
            r_active      <= THR_RESET;
            r_heater      <= 1'b0;
            r_cooler      <= 1'b0;
            r_fan         <= 1'b0;
        end else begin
            r_menu_active <= n_menu_active;
            r_selection   <= n_selection;
            r_edit        <= n_edit;
            r_active      <= n_active;
            r_heater      <= n_heater;
            r_cooler      <= n_cooler;
            r_fan         <= n_fan;
        end
    end

    // status after this item has been applied
    assign o_status.heater_on     = n_heater;
    assign o_status.cooler_on     = n_cooler;
    assign o_status.fan_on        = n_fan;
    assign o_status.setting_mode  = n_menu_active;
    assign o_status.selected_item = n_selection;
    assign o_status.key_code      = (i_item.func == FUNC_KEY) ? w_key : KEY_NONE;

    `CTC_ASSERT_NEXT(a_menu_sensor_hold,
        i_step && i_item.func == FUNC_SENSOR && r_menu_active,
        $stable(r_heater) && $stable(r_cooler) && $stable(r_fan))
    `CTC_ASSERT_NEXT(a_center_toggles,
        i_step && i_item.func == FUNC_KEY && w_key == KEY_CENTER,
        r_menu_active != $past(r_menu_active))
    `CTC_ASSERT_NEXT(a_commit_on_exit,
        i_step && i_item.func == FUNC_KEY && w_key == KEY_CENTER && r_menu_active,
        r_active == r_edit)
    `CTC_ASSERT_NOW(a_run_edit_frozen,
        !r_menu_active,
        n_edit == r_edit && n_selection == r_selection)

endmodule

`default_nettype wire
